[sv/weighted_channel_blend_top_macros.svh]
// Assertion macros for the weighted channel blend block.
`ifndef WEIGHTED_CHANNEL_BLEND_TOP_MACROS_SVH
`define WEIGHTED_CHANNEL_BLEND_TOP_MACROS_SVH

// same-cycle implication
`define WCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_channel_blend: same-cycle check failed");

// next-cycle implication
`define WCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_channel_blend: next-cycle check failed");

`endif

[sv/wcb_pkg.sv]
// Shared constants and codes for the weighted channel blend block.
package wcb_pkg;

  localparam int unsigned VAL_W   = 5;
  localparam int unsigned WGT_W   = 10;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 3;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam int unsigned DIV_IN_W  = 19;
  localparam int unsigned DIV_MAG_W = DIV_IN_W - 1;
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned DIV_SHIFT = 27;
  localparam int unsigned DIV_Q_W   = DIV_MAG_W + RECIP_W - DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(134218);

  localparam logic [WGT_W-1:0] PER_MILLE = WGT_W'(1000);
  localparam logic [VAL_W:0]   FULL_SCALE = 6'h20;
  localparam int               VAL_MAX = 31;

  localparam logic [CIDX_W-1:0] REG_BLEND_WEIGHT   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CHANNEL_WEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BLEND_MODE     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_INVERT_SOURCE  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_TABLE_KIND     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIFF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOD  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_TWO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

endpackage

[sv/wcb_div1000.sv]
// Two-stage signed divide by 1000, truncating toward zero, by reciprocal multiply.
module wcb_div1000 import wcb_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [DIV_IN_W-1:0] din,
  output logic signed [DIV_Q_W-1:0]  dout
);

  logic [DIV_MAG_W-1:0]         mag_nxt;
  logic [DIV_MAG_W+RECIP_W-1:0] prod_r;
  logic                         neg_r;
  logic [DIV_Q_W-2:0]           quo;
  logic signed [DIV_Q_W-1:0]    quo_s;
  logic signed [DIV_Q_W-1:0]    dout_nxt;
  logic signed [DIV_Q_W-1:0]    dout_r;

  assign mag_nxt  = din[DIV_IN_W-1] ? DIV_MAG_W'(-din) : DIV_MAG_W'(din);
  assign quo      = prod_r[DIV_MAG_W+RECIP_W-1:DIV_SHIFT];
  assign quo_s    = signed'({1'b0, quo});
  assign dout_nxt = neg_r ? -quo_s : quo_s;
  assign dout     = dout_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (DIV_MAG_W+RECIP_W)'(mag_nxt) * (DIV_MAG_W+RECIP_W)'(RECIP_1000);
      neg_r  <= din[DIV_IN_W-1];
      dout_r <= dout_nxt;
    end
  end

endmodule

[sv/weighted_channel_blend_top.sv]
// Throughput: one item per cycle; the pipeline holds only while out_tready is low.
// Path per item: weight multiply, divide by 1000, mode combine, second
// weight multiply, divide by 1000, clamp.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
`include "weighted_channel_blend_top_macros.svh"

module weighted_channel_blend_top import wcb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,    // [4:0] row_value, [9:5] column_value
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,   // [4:0] blended_value
  output logic                    out_tuser,   // [0] no_table
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [WGT_W-1:0]        cfg_data
);

  logic [WGT_W-1:0]  blend_weight_r;
  logic [WGT_W-1:0]  channel_weight_r;
  logic [MODE_W-1:0] blend_mode_r;
  logic              invert_source_r;
  logic [KIND_W-1:0] table_kind_r;

  logic       adv;
  logic [6:0] pipe_vld_r;
  logic       out_tvalid_r;
  logic       is_two;
  logic       is_mod;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;
  assign is_two    = (table_kind_r == KIND_TWO);
  assign is_mod    = is_two && (blend_mode_r == MODE_MOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r   <= PER_MILLE;
      channel_weight_r <= PER_MILLE;
      blend_mode_r     <= '0;
      invert_source_r  <= 1'b0;
      table_kind_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLEND_WEIGHT:   blend_weight_r   <= cfg_data;
        REG_CHANNEL_WEIGHT: channel_weight_r <= cfg_data;
        REG_BLEND_MODE:     blend_mode_r     <= cfg_data[MODE_W-1:0];
        REG_INVERT_SOURCE:  invert_source_r  <= cfg_data[0];
        REG_TABLE_KIND:     table_kind_r     <= cfg_data[KIND_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      pipe_vld_r   <= {pipe_vld_r[5:0], in_tvalid};
      out_tvalid_r <= pipe_vld_r[6];
    end
  end

  // stage 1: first weight multiply and keep product
  logic [VAL_W-1:0]           row_in;
  logic [VAL_W-1:0]           col_in;
  logic [VAL_W:0]             s_nxt;
  logic signed [7:0]          sx;
  logic signed [7:0]          cx;
  logic signed [7:0]          x1;
  logic signed [WGT_W:0]      y1;
  logic signed [WGT_W+1:0]    keep_w;
  logic signed [DIV_IN_W-1:0] p1_nxt;
  logic signed [DIV_IN_W-1:0] pk_nxt;
  logic signed [DIV_IN_W-1:0] p1_r;
  logic signed [DIV_IN_W-1:0] pk_r;
  logic [VAL_W:0]             s1_r, s2_r, s3_r;
  logic [VAL_W-1:0]           c1_r, c2_r, c3_r;

  assign row_in = in_tdata[VAL_W-1:0];
  assign col_in = in_tdata[2*VAL_W-1:VAL_W];
  assign s_nxt  = invert_source_r ? FULL_SCALE - {1'b0, row_in} : {1'b0, row_in};
  assign sx     = signed'({2'b00, s_nxt});
  assign cx     = signed'({3'b000, col_in});
  assign keep_w = signed'({2'b00, PER_MILLE}) - signed'({2'b00, blend_weight_r});

  always_comb begin
    x1 = sx;
    y1 = signed'({1'b0, blend_weight_r});
    if (!is_two) begin
      y1 = signed'({1'b0, channel_weight_r});
    end else begin
      case (blend_mode_r)
        MODE_ADD:  x1 = sx + cx;
        MODE_SUB:  x1 = cx - sx;
        MODE_DIFF: x1 = sx - cx;
        MODE_MOD: begin
          x1 = signed'({2'b00, FULL_SCALE});
          y1 = signed'({1'b0, channel_weight_r});
        end
        default:   x1 = sx;
      endcase
    end
    p1_nxt = DIV_IN_W'(x1) * DIV_IN_W'(y1);
    pk_nxt = DIV_IN_W'(keep_w) * DIV_IN_W'(cx);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= p1_nxt;
      pk_r <= pk_nxt;
      s1_r <= s_nxt;
      c1_r <= col_in;
      s2_r <= s1_r;
      c2_r <= c1_r;
      s3_r <= s2_r;
      c3_r <= c2_r;
    end
  end

  // stages 2-3: divide both products
  logic signed [DIV_Q_W-1:0] mq;
  logic signed [DIV_Q_W-1:0] kq;

  wcb_div1000 u_div_main (.clk(clk), .en(adv), .din(p1_r), .dout(mq));
  wcb_div1000 u_div_keep (.clk(clk), .en(adv), .din(pk_r), .dout(kq));

  // stage 4: combine per mode, pick second multiply operands
  logic signed [DIV_Q_W:0]   sum3;
  logic signed [DIV_Q_W:0]   c3s;
  logic signed [DIV_Q_W:0]   v3;
  logic [11:0]               mod_a;
  logic [10:0]               mod_b;
  logic [6:0]                mod_t;
  logic signed [DIV_Q_W:0]   x2_nxt;
  logic signed [WGT_W:0]     y2_nxt;
  logic signed [DIV_Q_W:0]   x2_r;
  logic signed [WGT_W:0]     y2_r;
  logic signed [DIV_Q_W-1:0] keep4_r, keep5_r, keep6_r, keep7_r;

  assign sum3  = (DIV_Q_W+1)'(mq) + (DIV_Q_W+1)'(kq);
  assign c3s   = signed'((DIV_Q_W+1)'(c3_r));
  assign mod_a = 12'(mq[VAL_W:0]) * 12'(s3_r);
  assign mod_b = 11'(FULL_SCALE - s3_r) * 11'(c3_r);
  assign mod_t = 7'(mod_a[11:5]) + 7'(mod_b[10:5]);

  always_comb begin
    v3 = sum3;
    case (blend_mode_r)
      MODE_ADD:  v3 = (sum3 < c3s) ? c3s : sum3;
      MODE_SUB:  v3 = (sum3 > c3s) ? c3s : sum3;
      MODE_DIFF: v3 = sum3;
      MODE_MOD:  v3 = sum3;
      default:   v3 = (s3_r == {1'b0, c3_r}) ? c3s : sum3;
    endcase
    if (!is_two) begin
      x2_nxt = (DIV_Q_W+1)'(mq);
      y2_nxt = signed'({1'b0, PER_MILLE});
    end else if (is_mod) begin
      x2_nxt = signed'((DIV_Q_W+1)'(mod_t));
      y2_nxt = signed'({1'b0, blend_weight_r});
    end else begin
      x2_nxt = v3;
      y2_nxt = signed'({1'b0, channel_weight_r});
    end
  end

  // stage 5: second weight multiply
  logic signed [DIV_IN_W-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r    <= x2_nxt;
      y2_r    <= y2_nxt;
      keep4_r <= kq;
      p2_r    <= DIV_IN_W'(x2_r * y2_r);
      keep5_r <= keep4_r;
      keep6_r <= keep5_r;
      keep7_r <= keep6_r;
    end
  end

  // stages 6-7: divide, stage 8: clamp into output register
  logic signed [DIV_Q_W-1:0] q2;
  logic signed [DIV_Q_W:0]   fin;
  logic [VAL_W-1:0]          res_nxt;
  logic [VAL_W-1:0]          res_r;
  logic                      none_r;

  wcb_div1000 u_div_out (.clk(clk), .en(adv), .din(p2_r), .dout(q2));

  assign fin = (DIV_Q_W+1)'(q2) + (is_mod ? (DIV_Q_W+1)'(keep7_r) : '0);

  always_comb begin
    if (table_kind_r == KIND_NONE || fin < 0) begin
      res_nxt = '0;
    end else if (fin > VAL_MAX) begin
      res_nxt = VAL_W'(VAL_MAX);
    end else begin
      res_nxt = fin[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      none_r <= (table_kind_r == KIND_NONE);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-VAL_W){1'b0}}, res_r};
  assign out_tuser  = none_r;

  `WCB_ASSERT_IMP(a_none_zero, out_tvalid && out_tuser, out_tdata[VAL_W-1:0] == '0)
  `WCB_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, $stable(pipe_vld_r))
  `WCB_ASSERT_NXT(a_drain, pipe_vld_r[6] && in_tready, out_tvalid)

endmodule

[test/weighted_channel_blend_top_tb.sv]
// Self-checking testbench: streams channel pairs through the blend block, checks each result.
module weighted_channel_blend_top_tb;
  import wcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MILLE = 1000;
  localparam int LONG_HOLD = 200;
  localparam int HOLD_AFTER = 150;
  localparam int TAIL_CYCLES = 12;
  localparam logic [MODE_W-1:0] MODE_XFADE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE_ALT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [VAL_W-1:0] col;
    logic [VAL_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             none;
  } blend_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CIDX_W-1:0]      cfg_index = '0;
  logic [WGT_W-1:0]       cfg_data = '0;

  logic [WGT_W-1:0]  w_blend = 10'd1000;
  logic [WGT_W-1:0]  w_chan = 10'd1000;
  logic [MODE_W-1:0] mode_sel = MODE_XFADE;
  logic              inv_src = 1'b0;
  logic [KIND_W-1:0] kind_sel = KIND_SINGLE;

  pixel_t pixel_queue[$];
  blend_t blend_expect_q[$];
  int     pixels_sent = 0;
  int     pixels_taken = 0;
  int     blends_seen = 0;
  int     mismatches = 0;
  int     idle_pct = 21;
  int     hold_left = 0;
  bit     held_once = 1'b0;

  weighted_channel_blend_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic blend_t blend_entry(input logic [VAL_W-1:0] row,
                                         input logic [VAL_W-1:0] col);
    blend_t res;
    int s, c, bw, cw, keep, v, a, b;
    res = '0;
    c = int'(col);
    s = inv_src ? 32 - int'(row) : int'(row);
    bw = int'(w_blend);
    cw = int'(w_chan);
    v = 0;
    if (kind_sel == KIND_NONE) begin
      res.none = 1'b1;
    end else if (kind_sel == KIND_TWO) begin
      keep = ((MILLE - bw) * c) / MILLE;
      case (mode_sel)
        MODE_ADD: begin
          v = (bw * (s + c)) / MILLE + keep;
          if (v < c) v = c;
        end
        MODE_SUB: begin
          v = (bw * (c - s)) / MILLE + keep;
          if (v > c) v = c;
        end
        MODE_DIFF: begin
          v = keep + ((s - c) * bw) / MILLE;
        end
        MODE_MOD: begin
          a = ((cw * 32) / MILLE) * s;
          b = (32 - s) * c;
          v = keep + ((a / 32 + b / 32) * bw) / MILLE;
        end
        default: begin
          v = (s == c) ? c : keep + (s * bw) / MILLE;
        end
      endcase
      if (mode_sel != MODE_MOD) v = (cw * v) / MILLE;
    end else begin
      v = (cw * s) / MILLE;
    end
    if (v < 0) v = 0;
    if (v > VAL_MAX) v = VAL_MAX;
    res.value = VAL_W'(v);
    return res;
  endfunction

  always @(posedge clk) begin : drive_pixels
    pixel_t nxt;
    logic   give;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        blend_expect_q.push_back(blend_entry(in_tdata[4:0], in_tdata[9:5]));
        pixels_taken++;
      end
      if (!in_tvalid || in_tready) begin
        give = (pixel_queue.size() != 0) && ($urandom_range(99, 0) >= idle_pct);
        if (give) begin
          nxt = pixel_queue.pop_front();
          in_tdata <= IN_TDATA_W'({nxt.col, nxt.row});
        end
        in_tvalid <= give;
      end
    end
  end

  always @(posedge clk) begin : check_blends
    blend_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        blends_seen++;
        if (blend_expect_q.size() == 0) begin
          $error("blended_value: expected none, actual %0d", out_tdata[4:0]);
          mismatches++;
        end else begin
          want = blend_expect_q.pop_front();
          if (out_tdata[4:0] !== want.value) begin
            $error("blended_value: expected %0d, actual %0d", want.value, out_tdata[4:0]);
            mismatches++;
          end
          if (out_tuser !== want.none) begin
            $error("no_table: expected %0d, actual %0d", want.none, out_tuser);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held_once && blends_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= idle_pct);
      end
    end
  end

  task automatic reg_write(input logic [CIDX_W-1:0] idx, input logic [WGT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BLEND_WEIGHT:   w_blend = data;
      REG_CHANNEL_WEIGHT: w_chan = data;
      REG_BLEND_MODE:     mode_sel = data[MODE_W-1:0];
      REG_INVERT_SOURCE:  inv_src = data[0];
      REG_TABLE_KIND:     kind_sel = data[KIND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixels_taken != pixels_sent || blend_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [WGT_W-1:0] bw, input logic [WGT_W-1:0] cw,
                          input logic [MODE_W-1:0] mode, input logic inv,
                          input logic [KIND_W-1:0] kind);
    wait_drained();
    reg_write(REG_BLEND_WEIGHT, bw);
    reg_write(REG_CHANNEL_WEIGHT, cw);
    reg_write(REG_BLEND_MODE, WGT_W'(mode));
    reg_write(REG_INVERT_SOURCE, WGT_W'(inv));
    reg_write(REG_TABLE_KIND, WGT_W'(kind));
  endtask

  task automatic send_pixel(input logic [VAL_W-1:0] row, input logic [VAL_W-1:0] col);
    pixel_queue.push_back('{col: col, row: row});
    pixels_sent++;
  endtask

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(5, 0))
      0: return 10'd0;
      1: return 10'd1000;
      2: return 10'd1023;
      default: return WGT_W'($urandom_range(1023, 0));
    endcase
  endfunction

  initial begin : stimulus
    int n;
    logic [VAL_W-1:0] row, col;
    logic [KIND_W-1:0] kind;
    logic inv;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    reg_write(REG_UNUSED, 10'h3ff);
    send_pixel(5'd0, 5'd0);
    send_pixel(5'd31, 5'd31);

    set_regs(10'd1023, 10'd1023, MODE_XFADE, 1'b1, KIND_SINGLE_ALT);
    send_pixel(5'd0, 5'd17);
    send_pixel(5'd31, 5'd0);

    set_regs(10'd1000, 10'd1000, MODE_ADD, 1'b0, KIND_TWO);
    send_pixel(5'd31, 5'd0);
    send_pixel(5'd0, 5'd31);
    send_pixel(5'd16, 5'd16);

    set_regs(10'd1023, 10'd500, MODE_SUB, 1'b0, KIND_TWO);
    send_pixel(5'd0, 5'd31);
    send_pixel(5'd31, 5'd0);
    send_pixel(5'd10, 5'd20);

    set_regs(10'd0, 10'd1000, MODE_DIFF, 1'b1, KIND_TWO);
    send_pixel(5'd0, 5'd31);
    send_pixel(5'd31, 5'd0);

    set_regs(10'd1000, 10'd1023, MODE_MOD, 1'b1, KIND_TWO);
    send_pixel(5'd0, 5'd31);
    send_pixel(5'd31, 5'd31);
    send_pixel(5'd16, 5'd8);

    set_regs(10'd700, 10'd0, MODE_XFADE, 1'b0, KIND_TWO);
    send_pixel(5'd5, 5'd5);
    send_pixel(5'd31, 5'd0);

    set_regs(10'd1000, 10'd1000, MODE_ADD, 1'b0, KIND_NONE);
    send_pixel(5'd31, 5'd31);
    send_pixel(5'd0, 5'd0);

    for (int p = 0; p < 17; p++) begin
      wait_drained();
      idle_pct = (p == 0) ? 0 : 21;
      n = (p == 0) ? 400 : 72;
      kind = ($urandom_range(1, 0) != 0) ? KIND_TWO : KIND_W'($urandom_range(3, 0));
      inv = 1'($urandom_range(1, 0));
      if (p == 1) reg_write(CIDX_W'($urandom_range(7, 5)), WGT_W'($urandom_range(1023, 0)));
      set_regs(rand_weight(), rand_weight(), MODE_W'($urandom_range(7, 0)), inv, kind);
      for (int k = 0; k < n; k++) begin
        row = VAL_W'($urandom_range(31, 0));
        col = VAL_W'($urandom_range(31, 0));
        if ($urandom_range(5, 0) == 0) col = inv ? VAL_W'(32 - int'(row)) : row;
        send_pixel(row, col);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/wcb_pkg.sv
sv/wcb_div1000.sv
sv/weighted_channel_blend_top.sv
test/weighted_channel_blend_top_tb.sv
